// ----- design/volume_convolution_3d_unit_assert.svh -----
// Assertion macros shared by the checker of the volume convolution unit.
// Each macro expects clk and rst in scope; no other dependencies.
`ifndef VOLUME_CONVOLUTION_3D_UNIT_ASSERT_SVH
`define VOLUME_CONVOLUTION_3D_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VC3D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VC3D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/vc3d_pkg.sv -----
// Shared types and constants of the volume convolution unit.
// No dependencies; imported by every design file.
`default_nettype none

package vc3d_pkg;

  localparam int OP_W      = 2;
  localparam int POS_W     = 6;
  localparam int WIDX_W    = 7;
  localparam int WEIGHT_W  = 24;
  localparam int VOXEL_W   = 16;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int K_W       = 3;
  localparam int COORD_W   = 11;

  localparam int VOXEL_MAX = 65535;

  localparam logic [OP_W-1:0] OP_WEIGHT = 2'd0;
  localparam logic [OP_W-1:0] OP_VOXEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_CLOAD,
    ST_TAPS,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic outside;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- design/vc3d_mac.sv -----
// Shared multiply-accumulate unit with clamp for the volume convolution unit.
// Depends on vc3d_pkg.
`default_nettype none

module vc3d_mac #(
  parameter int ACC_W = 50,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  vc3d_pkg::mac_ctrl_t                   ctrl,
  input  logic [vc3d_pkg::VOXEL_W-1:0]          voxel,
  input  logic [vc3d_pkg::VOXEL_W-1:0]          centre,
  input  logic signed [vc3d_pkg::WEIGHT_W-1:0]  weight,
  output logic                                  busy,
  output logic [vc3d_pkg::VOXEL_W-1:0]          value,
  output logic                                  clip
);
  import vc3d_pkg::*;

  localparam int PROD_W = VOXEL_W + WEIGHT_W + 1;
  localparam logic signed [ACC_W-1:0] TOP = ACC_W'(VOXEL_MAX) << WEIGHT_FRAC_BITS;

  logic [VOXEL_W-1:0]        sample;
  logic signed [PROD_W-1:0]  prod;
  logic                      prod_valid;
  logic signed [ACC_W-1:0]   acc;
  logic                      below;
  logic                      above;

  // Outside taps take the centre voxel.
  assign sample = ctrl.outside ? centre : voxel;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.take & ~ctrl.clear;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, sample}) * weight;
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign below = acc[ACC_W-1];
  assign above = acc > TOP;
  assign busy  = prod_valid;
  assign clip  = below | above;
  assign value = below ? '0 :
                 above ? VOXEL_W'(VOXEL_MAX) :
                 acc[WEIGHT_FRAC_BITS +: VOXEL_W];

endmodule

`default_nettype wire

// ----- design/volume_convolution_3d_unit.sv -----
// Sequence: writes are taken in ST_IDLE; a query walks ST_CENTRE, ST_CLOAD, ST_TAPS
//   for K^3 taps, ST_DRAIN, ST_FINISH (K the effective kernel edge; no taps at K zero).
// Throughput: one item at a time; a query reads one voxel and does one multiply-
//   accumulate per tap, holding the input off until its result is loaded, also while a result stalls.
// Reset: size registers return to 64, kernel size to 3; the voxel and weight
//   memories keep their contents and are undefined until written.
`default_nettype none

module volume_convolution_3d_unit #(
  parameter int MAX_DIM = 64,
  parameter int MAX_KERNEL = 5,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input item channel
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [vc3d_pkg::OP_W-1:0]             op,
  input  logic [vc3d_pkg::POS_W-1:0]            pos_x,
  input  logic [vc3d_pkg::POS_W-1:0]            pos_y,
  input  logic [vc3d_pkg::POS_W-1:0]            pos_z,
  input  logic [vc3d_pkg::WIDX_W-1:0]           weight_index,
  input  logic signed [vc3d_pkg::WEIGHT_W-1:0]  weight_value,
  input  logic [vc3d_pkg::VOXEL_W-1:0]          voxel_value,
  // result item channel
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [vc3d_pkg::VOXEL_W-1:0]          filtered_value,
  output logic                                  clipped,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [vc3d_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vc3d_pkg::CFG_W-1:0]            cfg_data
);
  import vc3d_pkg::*;

  // Voxel address is the concatenation of the three coordinates.
  localparam int DW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int VOX_DEPTH = 1 << (3 * DW);
  localparam int W_DEPTH   = MAX_KERNEL * MAX_KERNEL * MAX_KERNEL;
  localparam int TAP_W     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int ACC_W     = VOXEL_W + WEIGHT_W + 2 + TAP_W;
  localparam logic [COORD_W-1:0] DIM_CAP = COORD_W'(MAX_DIM);
  localparam logic [K_W-1:0]     K_CAP   = (MAX_KERNEL > 7) ? 3'd7 : K_W'(MAX_KERNEL);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] size_x;
  logic [CFG_W-1:0] size_y;
  logic [CFG_W-1:0] size_z;
  logic [K_W-1:0]   kernel_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x      <= CFG_W'(64);
      size_y      <= CFG_W'(64);
      size_z      <= CFG_W'(64);
      kernel_size <= K_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
        REG_KERNEL: kernel_size <= cfg_data[K_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate sizes to the store and K to the largest kernel held.
  logic [COORD_W-1:0] sx, sy, sz;
  logic [K_W-1:0]     k_eff;
  logic [K_W-1:0]     half;

  assign sx    = (COORD_W'(size_x) > DIM_CAP) ? DIM_CAP : COORD_W'(size_x);
  assign sy    = (COORD_W'(size_y) > DIM_CAP) ? DIM_CAP : COORD_W'(size_y);
  assign sz    = (COORD_W'(size_z) > DIM_CAP) ? DIM_CAP : COORD_W'(size_z);
  assign k_eff = (kernel_size > K_CAP) ? K_CAP : kernel_size;
  assign half  = k_eff >> 1;

  // ---------------------------------------------------------------------
  // Item acceptance and writes
  // ---------------------------------------------------------------------
  logic                     item_take;
  logic [COORD_W-1:0]       px, py, pz;
  logic                     pos_in_store;
  logic [TAP_W+WIDX_W-1:0]  widx_ext;
  logic                     w_we;
  logic                     vox_we;
  logic [3*DW-1:0]          vox_waddr;

  assign item_take    = item_valid & ~item_stall;
  assign px           = COORD_W'(pos_x);
  assign py           = COORD_W'(pos_y);
  assign pz           = COORD_W'(pos_z);
  assign pos_in_store = (px < DIM_CAP) && (py < DIM_CAP) && (pz < DIM_CAP);
  assign widx_ext     = (TAP_W + WIDX_W)'(weight_index);
  // Drop weight writes past the kernel store and voxel writes past the voxel store.
  assign w_we         = item_take && (op == OP_WEIGHT) && (int'(weight_index) < W_DEPTH);
  assign vox_we       = item_take && (op == OP_VOXEL) && pos_in_store;
  assign vox_waddr    = {px[DW-1:0], py[DW-1:0], pz[DW-1:0]};

  // Query registers: hold the centre for the whole walk.
  logic [COORD_W-1:0] qx, qy, qz;
  logic               q_in_store;

  always_ff @(posedge clk) begin
    if (item_take && (op == OP_QUERY)) begin
      qx         <= px;
      qy         <= py;
      qz         <= pz;
      q_in_store <= pos_in_store;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  state_t             state, state_next;
  logic [K_W-1:0]     kx, ky, kz;
  logic [TAP_W-1:0]   tap;
  logic [K_W-1:0]     k_last;
  logic               last_tap;
  logic               issue;
  logic               load_result;
  logic               s1_valid;
  logic               s1_outside;
  mac_ctrl_t          ctrl;
  logic               mac_busy;
  logic [VOXEL_W-1:0] mac_value;
  logic               mac_clip;

  assign k_last   = k_eff - K_W'(1);
  assign last_tap = (kx == k_last) && (ky == k_last) && (kz == k_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    item_stall   = 1'b1;
    issue        = 1'b0;
    load_result  = 1'b0;
    ctrl.clear   = 1'b0;
    ctrl.take    = s1_valid;
    ctrl.outside = s1_outside;
    case (state)
      ST_IDLE: begin
        // Hold the input off during reset; otherwise take any item.
        item_stall = rst;
        if (item_valid && (op == OP_QUERY)) begin
          state_next = ST_CENTRE;
        end
      end
      ST_CENTRE: begin
        // Read the centre voxel, clear the accumulator.
        ctrl.clear = 1'b1;
        state_next = ST_CLOAD;
      end
      ST_CLOAD: begin
        // An empty kernel skips the walk and gives zero.
        state_next = (k_eff == '0) ? ST_DRAIN : ST_TAPS;
      end
      ST_TAPS: begin
        issue = 1'b1;
        if (last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid && !mac_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Wait for the output register to free up.
        if (!result_valid || !result_stall) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Kernel counters: kz runs fastest, tap follows the flat weight index.
  always_ff @(posedge clk) begin
    if (state == ST_CLOAD) begin
      kx  <= '0;
      ky  <= '0;
      kz  <= '0;
      tap <= '0;
    end else if (issue) begin
      tap <= tap + TAP_W'(1);
      if (kz == k_last) begin
        kz <= '0;
        if (ky == k_last) begin
          ky <= '0;
          kx <= kx + K_W'(1);
        end else begin
          ky <= ky + K_W'(1);
        end
      end else begin
        kz <= kz + K_W'(1);
      end
    end
  end

  // Tap coordinates; negative values wrap high and fail the size compare.
  logic [COORD_W-1:0] vx, vy, vz;
  logic               tap_outside;
  logic [3*DW-1:0]    vox_raddr;

  assign vx          = qx + COORD_W'(kx) - COORD_W'(half);
  assign vy          = qy + COORD_W'(ky) - COORD_W'(half);
  assign vz          = qz + COORD_W'(kz) - COORD_W'(half);
  assign tap_outside = (vx >= sx) || (vy >= sy) || (vz >= sz);
  assign vox_raddr   = (state == ST_CENTRE) ? {qx[DW-1:0], qy[DW-1:0], qz[DW-1:0]}
                                            : {vx[DW-1:0], vy[DW-1:0], vz[DW-1:0]};

  // ---------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------
  logic [VOXEL_W-1:0]        vox_mem [VOX_DEPTH];
  logic [VOXEL_W-1:0]        vox_rdata;
  logic signed [WEIGHT_W-1:0] w_mem [W_DEPTH];
  logic signed [WEIGHT_W-1:0] w_rdata;

  always_ff @(posedge clk) begin
    if (vox_we) begin
      vox_mem[vox_waddr] <= voxel_value;
    end
    vox_rdata <= vox_mem[vox_raddr];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[widx_ext[TAP_W-1:0]] <= weight_value;
    end
    w_rdata <= w_mem[tap];
  end

  // Centre voxel; a centre beyond the store reads as zero.
  logic [VOXEL_W-1:0] centre;

  always_ff @(posedge clk) begin
    if (state == ST_CLOAD) begin
      centre <= q_in_store ? vox_rdata : '0;
    end
  end

  // Read stage flags travel alongside the memory read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_outside <= tap_outside;
  end

  vc3d_mac #(
    .ACC_W            (ACC_W),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .voxel  (vox_rdata),
    .centre (centre),
    .weight (w_rdata),
    .busy   (mac_busy),
    .value  (mac_value),
    .clip   (mac_clip)
  );

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      filtered_value <= mac_value;
      clipped        <= mac_clip;
    end
  end

endmodule

`default_nettype wire

// ----- design/vc3d_checker.sv -----
// Port-level checker for the volume convolution unit, bound to the top level.
// Depends on vc3d_pkg and volume_convolution_3d_unit_assert.svh.
`default_nettype none

`include "volume_convolution_3d_unit_assert.svh"

module vc3d_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  item_valid,
  input logic                                  item_stall,
  input logic [vc3d_pkg::OP_W-1:0]             op,
  input logic                                  result_valid,
  input logic                                  result_stall,
  input logic [vc3d_pkg::VOXEL_W-1:0]          filtered_value,
  input logic                                  clipped
);
  import vc3d_pkg::*;

  // Hold a stalled result.
  `VC3D_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid, "result dropped while stalled")
  `VC3D_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(filtered_value) && $stable(clipped), "stalled result changed")
  // A clamped sum shows one of the two rails.
  `VC3D_ASSERT_NOW(a_clip_rail, result_valid && clipped, filtered_value == 16'h0000 || filtered_value == 16'hFFFF, "clipped result off the rails")
  // A query occupies the unit right after acceptance.
  `VC3D_ASSERT_NEXT(a_query_busy, item_valid && !item_stall && op == OP_QUERY, item_stall, "input open during a query")

endmodule

bind volume_convolution_3d_unit vc3d_checker u_vc3d_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item_valid),
  .item_stall     (item_stall),
  .op             (op),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .filtered_value (filtered_value),
  .clipped        (clipped)
);

`default_nettype wire
